FILE: hdl/fbpa_pkg.sv
`timescale 1ns / 1ps
// shared constants and codes for the fixed block pool allocator
// no dependencies

package fbpa_pkg;

  localparam int unsigned MAX_BLOCKS_DEF = 256;
  localparam int unsigned INDEX_REACH    = 256;
  localparam int unsigned INDEX_W        = 8;
  localparam int unsigned COUNT_W        = 9;
  localparam int unsigned OP_W           = 2;
  localparam int unsigned STATUS_W       = 2;

  typedef logic [INDEX_W-1:0]  index_t;
  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [OP_W-1:0]     op_t;
  typedef logic [STATUS_W-1:0] status_t;

  // request codes
  localparam op_t OP_ALLOC = 2'd0;
  localparam op_t OP_FREE  = 2'd1;
  localparam op_t OP_CLEAR = 2'd2;
  localparam op_t OP_NONE  = 2'd3;

  // result status codes
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_EMPTY     = 2'd1;
  localparam status_t ST_RANGE     = 2'd2;
  localparam status_t ST_NOT_ALLOC = 2'd3;

endpackage

FILE: hdl/fbpa_ram.sv
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
// no dependencies

module fbpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/fixed_block_pool_allocator_top.sv
`timescale 1ns / 1ps
// fixed block pool allocator: lifo free list of block indices with allocated marks
// depends on fbpa_pkg and fbpa_ram (free stack storage)
// a result strobes out_valid in the cycle after its request beat is taken
// throughput: one request per cycle, busy stays low; the free stack ram is read at
// the accept edge and its registered output feeds the granted index
// reset: synchronous active-low rst_n empties the pool and sets block_count to 256

module fixed_block_pool_allocator_top #(
  parameter int unsigned MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  fbpa_pkg::op_t    in_operation,
  input  fbpa_pkg::index_t in_block_index,
  output logic             out_valid,
  output fbpa_pkg::index_t out_granted_index,
  output fbpa_pkg::status_t out_status,
  output fbpa_pkg::count_t out_free_blocks,
  input  logic             cfg_wr_en,
  input  fbpa_pkg::count_t cfg_wr_data
);

  import fbpa_pkg::*;

  localparam int unsigned CAP = (MAX_BLOCKS < INDEX_REACH) ? MAX_BLOCKS : INDEX_REACH;
  localparam int unsigned AW  = $clog2(CAP);
  localparam count_t CAP_C    = COUNT_W'(CAP);

  count_t  block_count_r;
  count_t  depth_r, depth_nxt;
  count_t  fresh_r, fresh_nxt;
  logic    mark_r [CAP];
  logic    mark_nxt [CAP];
  logic    out_valid_r;
  logic    pend_r, pend_nxt;
  index_t  granted_r, granted_nxt;
  status_t status_r, status_nxt;
  count_t  free_r, free_nxt;

  logic    accept;
  count_t  pool_n;
  count_t  depth_dec;
  count_t  fresh_cnt;
  logic    [AW-1:0] idx_a;
  logic    pend_hit;
  logic    is_marked;
  logic    push, set_fresh, clr_idx, clr_all;
  index_t  ram_rdata;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign pool_n    = (block_count_r > CAP_C) ? CAP_C : block_count_r;
  assign depth_dec = depth_r - COUNT_W'(1);
  assign idx_a     = in_block_index[AW-1:0];
  assign pend_hit  = pend_r && (ram_rdata == in_block_index);
  assign is_marked = mark_r[idx_a] || pend_hit;

  fbpa_ram #(
    .WIDTH (INDEX_W),
    .DEPTH (CAP)
  ) u_stack (
    .clk   (clk),
    .we    (push),
    .waddr (depth_r[AW-1:0]),
    .wdata (in_block_index),
    .raddr (depth_dec[AW-1:0]),
    .rdata (ram_rdata)
  );

  // request decode and state update
  always_comb begin
    depth_nxt   = depth_r;
    fresh_nxt   = fresh_r;
    status_nxt  = ST_OK;
    granted_nxt = '0;
    pend_nxt    = 1'b0;
    push        = 1'b0;
    set_fresh   = 1'b0;
    clr_idx     = 1'b0;
    clr_all     = 1'b0;
    if (accept) begin
      unique case (in_operation)
        OP_ALLOC: begin
          if (depth_r != '0) begin
            depth_nxt = depth_dec;
            pend_nxt  = 1'b1;
          end else if (fresh_r < pool_n) begin
            granted_nxt = fresh_r[INDEX_W-1:0];
            fresh_nxt   = fresh_r + COUNT_W'(1);
            set_fresh   = 1'b1;
          end else begin
            status_nxt = ST_EMPTY;
          end
        end
        OP_FREE: begin
          if ({1'b0, in_block_index} >= pool_n) begin
            status_nxt = ST_RANGE;
          end else if (!is_marked) begin
            status_nxt = ST_NOT_ALLOC;
          end else begin
            clr_idx = 1'b1;
            if (depth_r < CAP_C) begin
              push      = 1'b1;
              depth_nxt = depth_r + COUNT_W'(1);
            end
          end
        end
        OP_CLEAR: begin
          clr_all   = 1'b1;
          depth_nxt = '0;
          fresh_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  assign fresh_cnt = (fresh_nxt < pool_n) ? (pool_n - fresh_nxt) : '0;
  assign free_nxt  = depth_nxt + fresh_cnt;

  // allocated marks; a popped block is marked once its index leaves the ram
  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      mark_nxt[i] = mark_r[i];
      if (pend_r && ram_rdata[AW-1:0] == AW'(i)) begin
        mark_nxt[i] = 1'b1;
      end
      if (set_fresh && fresh_r[AW-1:0] == AW'(i)) begin
        mark_nxt[i] = 1'b1;
      end
      if (clr_idx && idx_a == AW'(i)) begin
        mark_nxt[i] = 1'b0;
      end
      if (clr_all || cfg_wr_en) begin
        mark_nxt[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_count_r <= COUNT_W'(INDEX_REACH);
      depth_r       <= '0;
      fresh_r       <= '0;
      out_valid_r   <= 1'b0;
      pend_r        <= 1'b0;
      for (int i = 0; i < CAP; i++) begin
        mark_r[i] <= 1'b0;
      end
    end else begin
      out_valid_r <= accept;
      pend_r      <= pend_nxt;
      for (int i = 0; i < CAP; i++) begin
        mark_r[i] <= mark_nxt[i];
      end
      if (cfg_wr_en) begin
        block_count_r <= cfg_wr_data;
        depth_r       <= '0;
        fresh_r       <= '0;
      end else begin
        depth_r <= depth_nxt;
        fresh_r <= fresh_nxt;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    granted_r <= granted_nxt;
    status_r  <= status_nxt;
    free_r    <= free_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_granted_index = pend_r ? ram_rdata : granted_r;
  assign out_status        = status_r;
  assign out_free_blocks   = free_r;

  // every stacked block was handed out fresh once
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= fresh_r)
    else $error("free stack deeper than blocks ever used");

  // a pop only comes with a result beat
  a_pend_beat: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> out_valid_r)
    else $error("stack pop without result beat");

  // a popped block must not already be marked allocated
  a_pop_free: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> !mark_r[ram_rdata[AW-1:0]])
    else $error("popped block already allocated");

  // fresh pointer stays within the pool capacity
  a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fresh_r <= CAP_C)
    else $error("never-used pointer past capacity");

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// testbench for fixed_block_pool_allocator_top: directed table rows, then random request
// phases across pool sizes; beats checked against the typed row or a free list predictor
// depends on fbpa_pkg and the allocator rtl

module tb;
  import fbpa_pkg::*;

  localparam int unsigned POOL_LIMIT = 256;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int N_DIR = 24;
  localparam int N_PHASE = 10;

  typedef struct packed {
    index_t  granted;
    status_t status;
    count_t  free_cnt;
  } reply_t;

  typedef struct packed {
    logic    is_cfg;
    count_t  cfg_val;
    op_t     op;
    index_t  idx;
    logic    typed;
    index_t  granted;
    status_t status;
    count_t  free_cnt;
  } dir_row_t;

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    start = 1'b0;
  logic    busy;
  op_t     in_operation = OP_ALLOC;
  index_t  in_block_index = '0;
  logic    out_valid;
  index_t  out_granted_index;
  status_t out_status;
  count_t  out_free_blocks;
  logic    cfg_wr_en = 1'b0;
  count_t  cfg_wr_data = '0;

  always #5 clk = ~clk;

  fixed_block_pool_allocator_top u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_operation      (in_operation),
    .in_block_index    (in_block_index),
    .out_valid         (out_valid),
    .out_granted_index (out_granted_index),
    .out_status        (out_status),
    .out_free_blocks   (out_free_blocks),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  // predicted pool state
  index_t      free_lifo [POOL_LIMIT];
  bit          owned [POOL_LIMIT];
  int unsigned lifo_depth = 0;
  int unsigned fresh_next = 0;
  count_t      pool_cfg = count_t'(POOL_LIMIT);

  reply_t      reply_q [$];
  logic        item_typed = 1'b0;
  reply_t      item_reply = '0;
  int unsigned n_accepted = 0;
  int unsigned n_errors = 0;
  int unsigned quiet_cycles = 0;

  dir_row_t dir_rows [N_DIR] = '{
    '{1'b0, 9'd0,   OP_ALLOC, 8'd0,   1'b1, 8'd0, ST_OK,        9'd255},
    '{1'b0, 9'd0,   OP_ALLOC, 8'd0,   1'b1, 8'd1, ST_OK,        9'd254},
    '{1'b0, 9'd0,   OP_FREE,  8'd255, 1'b1, 8'd0, ST_NOT_ALLOC, 9'd254},
    '{1'b0, 9'd0,   OP_FREE,  8'd0,   1'b1, 8'd0, ST_OK,        9'd255},
    '{1'b0, 9'd0,   OP_FREE,  8'd0,   1'b1, 8'd0, ST_NOT_ALLOC, 9'd255},
    '{1'b0, 9'd0,   OP_ALLOC, 8'd255, 1'b1, 8'd0, ST_OK,        9'd254},
    '{1'b0, 9'd0,   OP_NONE,  8'd255, 1'b1, 8'd0, ST_OK,        9'd254},
    '{1'b0, 9'd0,   OP_CLEAR, 8'd0,   1'b1, 8'd0, ST_OK,        9'd256},
    '{1'b0, 9'd0,   OP_FREE,  8'd1,   1'b1, 8'd0, ST_NOT_ALLOC, 9'd256},
    '{1'b1, 9'd1,   OP_ALLOC, 8'd0,   1'b0, 8'd0, ST_OK,        9'd0},
    '{1'b0, 9'd0,   OP_ALLOC, 8'd0,   1'b1, 8'd0, ST_OK,        9'd0},
    '{1'b0, 9'd0,   OP_ALLOC, 8'd0,   1'b1, 8'd0, ST_EMPTY,     9'd0},
    '{1'b0, 9'd0,   OP_FREE,  8'd1,   1'b1, 8'd0, ST_RANGE,     9'd0},
    '{1'b0, 9'd0,   OP_FREE,  8'd255, 1'b1, 8'd0, ST_RANGE,     9'd0},
    '{1'b0, 9'd0,   OP_FREE,  8'd0,   1'b1, 8'd0, ST_OK,        9'd1},
    '{1'b1, 9'd0,   OP_ALLOC, 8'd0,   1'b0, 8'd0, ST_OK,        9'd0},
    '{1'b0, 9'd0,   OP_ALLOC, 8'd0,   1'b1, 8'd0, ST_EMPTY,     9'd0},
    '{1'b0, 9'd0,   OP_FREE,  8'd0,   1'b1, 8'd0, ST_RANGE,     9'd0},
    '{1'b1, 9'd511, OP_ALLOC, 8'd0,   1'b0, 8'd0, ST_OK,        9'd0},
    '{1'b0, 9'd0,   OP_ALLOC, 8'd0,   1'b1, 8'd0, ST_OK,        9'd255},
    '{1'b0, 9'd0,   OP_FREE,  8'd0,   1'b1, 8'd0, ST_OK,        9'd256},
    '{1'b1, 9'd256, OP_ALLOC, 8'd0,   1'b0, 8'd0, ST_OK,        9'd0},
    '{1'b0, 9'd0,   OP_ALLOC, 8'd170, 1'b0, 8'd0, ST_OK,        9'd0},
    '{1'b0, 9'd0,   OP_CLEAR, 8'd85,  1'b0, 8'd0, ST_OK,        9'd0}
  };

  function automatic int unsigned pool_blocks();
    return (pool_cfg > POOL_LIMIT) ? POOL_LIMIT : int'(pool_cfg);
  endfunction

  task automatic empty_pool();
    lifo_depth = 0;
    fresh_next = 0;
    for (int i = 0; i < POOL_LIMIT; i++) owned[i] = 1'b0;
  endtask

  task automatic pool_request(input op_t op, input index_t idx, output reply_t r);
    int unsigned n;
    n = pool_blocks();
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_ALLOC: begin
        if (lifo_depth > 0) begin
          lifo_depth--;
          r.granted = free_lifo[lifo_depth];
          owned[r.granted] = 1'b1;
        end else if (fresh_next < n) begin
          r.granted = index_t'(fresh_next);
          fresh_next++;
          owned[r.granted] = 1'b1;
        end else begin
          r.status = ST_EMPTY;
        end
      end
      OP_FREE: begin
        if (idx >= n) begin
          r.status = ST_RANGE;
        end else if (!owned[idx]) begin
          r.status = ST_NOT_ALLOC;
        end else begin
          owned[idx] = 1'b0;
          free_lifo[lifo_depth] = idx;
          lifo_depth++;
        end
      end
      OP_CLEAR: empty_pool();
      default: ;
    endcase
    r.free_cnt = count_t'(lifo_depth + ((fresh_next < n) ? n - fresh_next : 0));
  endtask

  always @(posedge clk) begin : monitor
    reply_t want;
    reply_t got;
    if (!rst_n) begin
      pool_cfg = count_t'(POOL_LIMIT);
      empty_pool();
    end else begin
      if (out_valid === 1'b1) begin
        got.granted = out_granted_index;
        got.status = out_status;
        got.free_cnt = out_free_blocks;
        if (reply_q.size() == 0) begin
          $error("unexpected result beat: granted_index %0d status %0d free_blocks %0d",
                 got.granted, got.status, got.free_cnt);
          n_errors++;
        end else begin
          want = reply_q.pop_front();
          if (got.granted !== want.granted) begin
            $error("granted_index: expected %0d, actual %0d", want.granted, got.granted);
            n_errors++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            n_errors++;
          end
          if (got.free_cnt !== want.free_cnt) begin
            $error("free_blocks: expected %0d, actual %0d", want.free_cnt, got.free_cnt);
            n_errors++;
          end
        end
      end
      if (cfg_wr_en) begin
        pool_cfg = cfg_wr_data;
        empty_pool();
      end
      if (start && !busy) begin
        pool_request(in_operation, in_block_index, want);
        reply_q.push_back(item_typed ? item_reply : want);
        n_accepted++;
      end
      if ((start && !busy) || out_valid === 1'b1) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("fixed_block_pool_allocator_top verification failed");
        $finish;
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the beat is taken
  task automatic send_req(input op_t op, input index_t idx, input logic typed,
                          input reply_t r);
    int unsigned base;
    base = n_accepted;
    in_operation = op;
    in_block_index = idx;
    item_typed = typed;
    item_reply = r;
    start = 1'b1;
    while (n_accepted == base) @(negedge clk);
  endtask

  task automatic wait_drained();
    start = 1'b0;
    while (reply_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_count(input count_t v);
    wait_drained();
    repeat (2) @(negedge clk);
    cfg_wr_data = v;
    cfg_wr_en = 1'b1;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  initial begin : stimulus
    count_t      phase_cfg [N_PHASE];
    int unsigned phase_items [N_PHASE];
    int unsigned n;
    int unsigned w;
    int unsigned r;
    int unsigned gap;
    int unsigned pick;
    bit          calm;
    bit          found;
    bit          filling;
    op_t         op;
    index_t      idx;
    reply_t      row_reply;

    phase_cfg = '{9'd256, 9'd3, 9'd1, 9'd2, 9'd40, 9'd256, 9'd0, 9'd511, 9'd4, 9'd130};
    phase_items = '{320, 80, 80, 80, 80, 160, 30, 160, 80, 80};
    phase_cfg[8] = count_t'($urandom_range(4, 255));

    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < N_DIR; i++) begin
      if (dir_rows[i].is_cfg) begin
        write_count(dir_rows[i].cfg_val);
      end else begin
        row_reply.granted = dir_rows[i].granted;
        row_reply.status = dir_rows[i].status;
        row_reply.free_cnt = dir_rows[i].free_cnt;
        send_req(dir_rows[i].op, dir_rows[i].idx, dir_rows[i].typed, row_reply);
      end
    end

    for (int p = 0; p < N_PHASE; p++) begin
      write_count(phase_cfg[p]);
      n = pool_blocks();
      calm = (p % 3 == 1);
      w = 50;
      for (int k = 0; k < phase_items[p]; k++) begin
        // first phase fills the whole pool to reach the empty case
        filling = (p == 0 && k < 280);
        if (k % 32 == 0) w = $urandom_range(15, 95);
        if (filling) w = 100;
        r = $urandom_range(0, 99);
        idx = index_t'($urandom_range(0, 255));
        if (r < 2 && !filling) begin
          op = OP_CLEAR;
        end else if (r < 4) begin
          op = OP_NONE;
        end else if (r < 4 + w * 96 / 100) begin
          op = OP_ALLOC;
        end else begin
          op = OP_FREE;
          r = $urandom_range(0, 9);
          if (r < 8 && n > 0) begin
            pick = $urandom_range(0, n - 1);
            found = 1'b0;
            for (int s = 0; s < n && !found; s++) begin
              if (owned[(pick + s) % n]) begin
                idx = index_t'((pick + s) % n);
                found = 1'b1;
              end
            end
          end else if (r == 8 && n > 0) begin
            idx = index_t'($urandom_range(0, n - 1));
          end
        end
        send_req(op, idx, 1'b0, '0);
        if (k == 40 || $urandom_range(0, 199) == 0) wait_drained();
        if (!calm) begin
          r = $urandom_range(0, 99);
          gap = (r < 70) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(8, 40);
          if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
          end
        end
      end
    end

    wait_drained();
    repeat (4) @(negedge clk);
    if (n_errors == 0) begin
      $display("fixed_block_pool_allocator_top verification clean");
    end else begin
      $display("fixed_block_pool_allocator_top verification failed");
    end
    $finish;
  end

endmodule
